@@ rtl/core/lfa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfa_pkg
// Shared constants and types of the lowest-free identifier allocator.
// ----------------------------------------------------------------------------
package lfa_pkg;

	// default number of identifiers, 0 included
	localparam int ID_COUNT_DEF = 1024;

	// fixed field widths of the command and result ports
	localparam int ID_FIELD_W = 10;
	localparam int STATUS_W   = 2;

	// command codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_ZERO      = 2'd1,
		ST_DOUBLE    = 2'd2,
		ST_EXHAUSTED = 2'd3
	} status_t;

endpackage
`default_nettype wire

@@ rtl/core/lfa_lsb_enc.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfa_lsb_enc
// Lowest-set-bit encoder: isolates the lowest one with a two's complement
// and ORs the index bits of that single position.
// ----------------------------------------------------------------------------
module lfa_lsb_enc
	import lfa_pkg::*;
#(
	parameter int WIDTH = 32,
	parameter int IDX_W = 5
) (
	input  wire logic [WIDTH-1:0] vec,
	output logic      [IDX_W-1:0] idx,
	output logic                  any
);

	logic [WIDTH-1:0] lowest;

	// one-hot of the lowest set bit
	assign lowest = vec & (~vec + {{(WIDTH-1){1'b0}}, 1'b1});
	assign any    = |vec;

	// encode the one-hot position
	always_comb begin
		idx = '0;
		for (int b = 0; b < IDX_W; b++) begin
			for (int i = 0; i < WIDTH; i++) begin
				if (i[b]) begin
					idx[b] = idx[b] | lowest[i];
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/lfa_word_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfa_word_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lfa_word_ram
	import lfa_pkg::*;
#(
	parameter int DEPTH  = 32,
	parameter int ADDR_W = 5,
	parameter int DATA_W = 32
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/lowest_free_id_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Hands out the lowest freed identifier, else a fresh one; takes them back.
// ----------------------------------------------------------------------------
// Start is taken while busy is low; the cycle after it reads one bitmap
// word from the RAM and writes it back when an identifier is taken from it
// or returned to it, and the result appears for one cycle on done in the
// cycle that follows, when busy is already low again, so a new command may
// be issued while done is high. The free bitmap is kept as words of one RAM
// row each, with a summary flop per row that says the row holds a free
// identifier; the summary is cleared at reset, so the bitmap is usable at
// once, with no clearing pass. Results cannot be held off: done is a one-cycle strobe.
module lowest_free_id_allocator
	import lfa_pkg::*;
#(
	parameter int ID_COUNT = ID_COUNT_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  op,
	input  wire logic [ID_FIELD_W-1:0] free_id,
	output logic                       done,
	output logic      [ID_FIELD_W-1:0] given_id,
	output logic      [STATUS_W-1:0]   status
);

	// bitmap geometry: about square, rows x words
	localparam int ID_W       = $clog2(ID_COUNT);
	localparam int WORD_IDX_W = (ID_W + 1) / 2;
	localparam int WORD_W     = 1 << WORD_IDX_W;
	localparam int ROW_IDX_W  = ID_W - WORD_IDX_W;
	localparam int ROWS       = (ID_COUNT + WORD_W - 1) / WORD_W;
	localparam int CNT_W      = ID_W + 1;

	typedef enum logic {
		S_IDLE,
		S_LOOKUP
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      fresh_q;
	logic [ROWS-1:0]       summary_q;

	// command captured at accept
	logic                  op_s1;
	logic                  hit_s1;
	logic                  bad_s1;
	logic [ROW_IDX_W-1:0]  row_s1;
	logic [WORD_IDX_W-1:0] bit_s1;

	// accept-time decode
	logic                  accept;
	logic [31:0]           free_ext;
	logic [ID_W-1:0]       free_low;
	logic                  free_bad;
	logic [ROW_IDX_W-1:0]  low_row;
	logic                  any_free;
	logic [ROW_IDX_W-1:0]  rd_row;

	// lookup cycle
	logic [WORD_W-1:0]     rd_data;
	logic [WORD_W-1:0]     word;
	logic [WORD_IDX_W-1:0] low_bit;
	logic                  word_any;
	logic [WORD_W-1:0]     bit_mask;
	logic [WORD_W-1:0]     low_mask;
	logic                  wr_en;
	logic [WORD_W-1:0]     wr_word;
	logic [ID_W-1:0]       hit_id;
	logic [31:0]           hit_ext;
	logic [31:0]           fresh_ext;
	logic [ID_FIELD_W-1:0] res_id;
	status_t               res_status;
	logic                  fresh_take;

	assign accept = start && !busy;
	assign busy   = (state_q == S_LOOKUP);

	// free id range check and split into row and bit
	assign free_ext = 32'(free_id);
	assign free_low = free_ext[ID_W-1:0];
	assign free_bad = (free_ext == 32'd0) || (free_ext >= 32'(ID_COUNT));

	// lowest row with a free identifier
	lfa_lsb_enc #(
		.WIDTH (ROWS),
		.IDX_W (ROW_IDX_W)
	) u_row_enc (
		.vec (summary_q),
		.idx (low_row),
		.any (any_free)
	);

	assign rd_row = (op == OP_ALLOC) ? low_row : free_low[ID_W-1:WORD_IDX_W];

	lfa_word_ram #(
		.DEPTH  (ROWS),
		.ADDR_W (ROW_IDX_W),
		.DATA_W (WORD_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (rd_row),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (row_s1),
		.wr_data (wr_word)
	);

	// a row whose summary bit is clear holds no free id, whatever the RAM has
	assign word = summary_q[row_s1] ? rd_data : '0;

	lfa_lsb_enc #(
		.WIDTH (WORD_W),
		.IDX_W (WORD_IDX_W)
	) u_bit_enc (
		.vec (word),
		.idx (low_bit),
		.any (word_any)
	);

	assign bit_mask  = {{(WORD_W-1){1'b0}}, 1'b1} << bit_s1;
	assign low_mask  = {{(WORD_W-1){1'b0}}, 1'b1} << low_bit;
	assign hit_id    = {row_s1, low_bit};
	assign hit_ext   = 32'(hit_id);
	assign fresh_ext = 32'(fresh_q);

	// modify the word and form the result
	always_comb begin
		wr_en      = 1'b0;
		wr_word    = word;
		res_id     = '0;
		res_status = ST_OK;
		fresh_take = 1'b0;
		if (op_s1 == OP_ALLOC) begin
			if (hit_s1) begin
				wr_en   = 1'b1;
				wr_word = word & ~low_mask;
				res_id  = hit_ext[ID_FIELD_W-1:0];
			end else if (fresh_q < CNT_W'(ID_COUNT)) begin
				fresh_take = 1'b1;
				res_id     = fresh_ext[ID_FIELD_W-1:0];
			end else begin
				res_status = ST_EXHAUSTED;
			end
		end else begin
			if (bad_s1) begin
				res_status = ST_ZERO;
			end else if ((word & bit_mask) != '0) begin
				res_status = ST_DOUBLE;
			end else begin
				wr_en   = 1'b1;
				wr_word = word | bit_mask;
			end
		end
	end

	// state, fresh counter, summary and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fresh_q   <= CNT_W'(1);
			summary_q <= '0;
			done      <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_LOOKUP;
					end
				end
				S_LOOKUP: begin
					state_q <= S_IDLE;
					done    <= 1'b1;
					if (fresh_take) begin
						fresh_q <= fresh_q + CNT_W'(1);
					end
					if (wr_en) begin
						summary_q[row_s1] <= (wr_word != '0);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op;
			hit_s1 <= any_free;
			bad_s1 <= free_bad;
			row_s1 <= rd_row;
			bit_s1 <= free_low[WORD_IDX_W-1:0];
		end
		if (state_q == S_LOOKUP) begin
			given_id <= res_id;
			status   <= res_status;
		end
	end

	// an accepted command is looked up in the next cycle, answered after it
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy ##1 done)
		else $error("accepted command not answered in two cycles");

	// the strobe only follows a lookup cycle
	a_done_after_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_LOOKUP))
		else $error("result strobe without lookup");

	// only a successful allocate hands out a nonzero identifier
	a_id_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != ST_OK) |-> given_id == '0)
		else $error("identifier given with error status");

	// an allocate from the bitmap always finds a bit in the flagged row
	a_hit_word_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy && (op_s1 == OP_ALLOC) && hit_s1 |-> word_any)
		else $error("summary flags a row with no free identifier");

endmodule
`default_nettype wire
